### rtl/core/spl_pkg.sv
// Shared types and constants for the sorted priority list.
// Request and result structs, operation codes, controller states and
// the command/status bundles between controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package spl_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int ITEM_WIDTH_DEF = 32;
  localparam int DATA_W         = 32;
  localparam int KEY_W          = 32;
  localparam int COUNT_W        = 5;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_PREPEND = 2'd1,
    OP_SORTED  = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                      opcode;
    logic [DATA_W-1:0]        item_value;
    logic signed [KEY_W-1:0]  sort_key;
  } req_t;

  typedef struct packed {
    logic                     removed_valid;
    logic [DATA_W-1:0]        removed_item;
    logic signed [KEY_W-1:0]  removed_key;
    logic                     insert_dropped;
    logic                     is_empty;
    logic [COUNT_W-1:0]       entry_count;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_PROC,
    ST_TAIL,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic proc;
    logic tail;
    logic respond;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic occ_zero;
    logic drop;
    logic last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/spl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/spl_ctrl.sv
// Controller state machine of the sorted priority list.
// Uses spl_pkg; drives commands to spl_dp from its status.
`timescale 1ns / 1ps
`default_nettype none

module spl_ctrl
  import spl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output      logic in_ready,
  input  wire sts_t sts,
  output      cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_START;
      end
      ST_START: begin
        if (sts.op == OP_REMOVE) begin
          state_next = sts.occ_zero ? ST_RESP : ST_READ;
        end else if (sts.drop) begin
          state_next = ST_RESP;
        end else if (sts.op == OP_APPEND || sts.occ_zero) begin
          state_next = ST_TAIL;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_PROC;
      end
      ST_PROC: begin
        if (!sts.last) begin
          state_next = ST_READ;
        end else if (sts.op == OP_REMOVE) begin
          state_next = ST_RESP;
        end else begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (!sts.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_START: ;
      ST_READ:  cmd.rd = 1'b1;
      ST_PROC:  cmd.proc = 1'b1;
      ST_TAIL:  cmd.tail = 1'b1;
      ST_RESP:  cmd.respond = !sts.out_busy;
      default: ;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.rd, cmd.proc, cmd.tail, cmd.respond}))
    else $error("more than one command at once");

  a_rd_then_proc: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |=> cmd.proc)
    else $error("read not followed by process step");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == ST_START))
    else $error("accepted request did not start");

endmodule

`default_nettype wire

### rtl/core/spl_dp.sv
// Datapath of the sorted priority list: entry RAM, occupancy, scan index,
// carried entry and result register. Uses spl_pkg and spl_ram.
`timescale 1ns / 1ps
`default_nettype none

module spl_dp
  import spl_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t in_data,
  input  wire cmd_t cmd,
  output      sts_t sts,
  output      logic out_valid,
  input  wire logic out_ready,
  output      res_t out_data
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = ITEM_WIDTH + KEY_W;

  logic [OCC_W-1:0]        occ;
  logic [IDX_W-1:0]        idx;
  op_t                     op;
  logic [ITEM_WIDTH-1:0]   new_item;
  logic signed [KEY_W-1:0] new_key;
  logic [ENTRY_W-1:0]      carry;
  logic                    placed;
  logic                    drop_flag;
  logic                    remove_hit;
  logic [ENTRY_W-1:0]      head;

  logic                    we;
  logic [IDX_W-1:0]        waddr;
  logic [ENTRY_W-1:0]      wdata;
  logic [ENTRY_W-1:0]      rdata;
  logic [ENTRY_W-1:0]      new_entry;
  logic signed [KEY_W-1:0] rd_key;
  logic                    take_new;
  logic [ITEM_WIDTH+DATA_W-1:0] item_in_wide;
  logic [ITEM_WIDTH+DATA_W-1:0] item_out_wide;
  logic [OCC_W+COUNT_W-1:0]     count_wide;

  assign item_in_wide  = {{ITEM_WIDTH{1'b0}}, in_data.item_value};
  assign item_out_wide = {{DATA_W{1'b0}}, head[ENTRY_W-1:KEY_W]};
  assign count_wide    = {{COUNT_W{1'b0}}, occ};
  assign new_entry     = {new_item, new_key};
  assign rd_key        = $signed(rdata[KEY_W-1:0]);
  assign take_new      = !placed && ((op == OP_PREPEND && idx == '0) ||
                                     (op == OP_SORTED && rd_key > new_key));

  spl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd),
    .raddr(idx),
    .rdata(rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = new_entry;
    if (cmd.proc) begin
      if (op == OP_REMOVE) begin
        if (idx != '0) begin
          we    = 1'b1;
          waddr = idx - 1'b1;
          wdata = rdata;
        end
      end else if (placed) begin
        we    = 1'b1;
        wdata = carry;
      end else if (take_new) begin
        we    = 1'b1;
      end
    end
    if (cmd.tail) begin
      we    = 1'b1;
      waddr = occ[IDX_W-1:0];
      wdata = placed ? carry : new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ        <= '0;
      out_valid  <= 1'b0;
      placed     <= 1'b0;
      drop_flag  <= 1'b0;
      remove_hit <= 1'b0;
      idx        <= '0;
      op         <= OP_APPEND;
    end else begin
      if (cmd.accept) begin
        op         <= in_data.opcode;
        idx        <= '0;
        placed     <= 1'b0;
        drop_flag  <= (in_data.opcode != OP_REMOVE) && (occ == OCC_W'(DEPTH));
        remove_hit <= (in_data.opcode == OP_REMOVE) && (occ != '0);
      end
      if (cmd.proc) begin
        idx <= idx + 1'b1;
        if (op != OP_REMOVE && take_new) placed <= 1'b1;
        if (op == OP_REMOVE && sts.last) occ <= occ - 1'b1;
      end
      if (cmd.tail) begin
        occ <= occ + 1'b1;
      end
      if (cmd.respond) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      new_item <= item_in_wide[ITEM_WIDTH-1:0];
      new_key  <= (in_data.opcode == OP_SORTED) ? in_data.sort_key : '0;
    end
    if (cmd.proc) begin
      if (op == OP_REMOVE) begin
        if (idx == '0) head <= rdata;
      end else if (placed || take_new) begin
        carry <= rdata;
      end
    end
    if (cmd.respond) begin
      out_data.removed_valid  <= remove_hit;
      out_data.removed_item   <= remove_hit ? item_out_wide[DATA_W-1:0] : '0;
      out_data.removed_key    <= remove_hit ? $signed(head[KEY_W-1:0]) : '0;
      out_data.insert_dropped <= drop_flag;
      out_data.is_empty       <= (occ == '0);
      out_data.entry_count    <= count_wide[COUNT_W-1:0];
    end
  end

  always_comb begin
    sts.op       = op;
    sts.occ_zero = (occ == '0);
    sts.drop     = drop_flag;
    sts.last     = ((OCC_W'(idx) + 1'b1) == occ);
    sts.out_busy = out_valid && !out_ready;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_tail_room: assert property (@(posedge clk) disable iff (rst)
    cmd.tail |-> (occ < OCC_W'(DEPTH)))
    else $error("tail write into full store");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |-> !(out_valid && !out_ready))
    else $error("result overwritten before it was taken");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    !(drop_flag && remove_hit))
    else $error("drop and remove flagged together");

endmodule

`default_nettype wire

### rtl/core/sorted_priority_list.sv
// Sorted priority list: bounded ordered list of tagged entries with signed keys.
// A dropped insert or an empty remove goes straight to the response; an append writes only
// the tail entry; prepend, sorted insert and remove scan the N entries held, reading and then
// moving each in turn on the one RAM port pair, and inserts then write the tail entry.
// One request at a time; the next is taken in the cycle after the result is registered, also
// while it waits; a result still held up stalls the next response. Synchronous reset
// empties the list at once; stored entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_list
  import spl_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output      logic in_ready,
  input  wire req_t in_data,
  output      logic out_valid,
  input  wire logic out_ready,
  output      res_t out_data
);

  cmd_t cmd;
  sts_t sts;

  spl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  spl_dp #(
    .DEPTH     (DEPTH),
    .ITEM_WIDTH(ITEM_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
